// ===== hw/rtl/priority_voice_allocator_assert.svh =====
// assertion macros for the voice allocator
`ifndef PRIORITY_VOICE_ALLOCATOR_ASSERT_SVH
`define PRIORITY_VOICE_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define PVA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PVA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/pva_pkg.sv =====
`timescale 1ns / 1ps

package pva_pkg;

  localparam int PRIO_W    = 8;
  localparam int TIME_IN_W = 32;
  localparam int SLOT_W    = 5;
  localparam int MASK_W    = 32;
  localparam int GEN_W     = 32;

  localparam logic [PRIO_W-1:0] PRIO_IDLE = 8'hFF;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef struct packed {
    logic                 opcode;
    logic [PRIO_W-1:0]    request_priority;
    logic [TIME_IN_W-1:0] request_time;
    logic [SLOT_W-1:0]    voice_slot;
    logic [MASK_W-1:0]    mixer_active_mask;
  } req_t;

  typedef struct packed {
    logic              granted;
    logic [SLOT_W-1:0] granted_slot;
    logic [GEN_W-1:0]  generation;
  } rsp_t;

endpackage

// ===== hw/rtl/pva_voice_mem.sv =====
`timescale 1ns / 1ps

module pva_voice_mem #(
  parameter int                DEPTH = 32,
  parameter int                WIDTH = 73,
  parameter logic [WIDTH-1:0]  FILL  = '0
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [WIDTH-1:0] q;
  logic             hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q <= mem[rd_addr];
    end
  end

  // entries never written read as the reset word
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      hit   <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        hit <= valid[rd_addr];
      end
    end
  end

  assign rd_data = hit ? q : FILL;

endmodule

// ===== hw/rtl/priority_voice_allocator.sv =====
`timescale 1ns / 1ps

// Voice allocator: start is taken when busy is low; each item gives exactly one
// result, shown on result for one cycle with done high, and the receiver cannot
// stall it. An allocate scans the voices through a single read port of the voice
// memory, one voice per cycle from a rotating offset, stopping at the first free
// voice, else granting the oldest voice of equal or larger priority value, if any;
// done follows as busy falls. A release is a read and a write of the named voice:
// busy for one cycle. A release naming a voice of NUM_VOICES or more answers in the
// next cycle without going busy. All voices read as idle right after reset.

module priority_voice_allocator #(
  parameter int NUM_VOICES = 32,
  parameter int TIME_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  pva_pkg::req_t req,
  output logic          busy,
  output logic          done,
  output pva_pkg::rsp_t result
);

  `include "priority_voice_allocator_assert.svh"

  localparam int IW = $clog2(NUM_VOICES);
  localparam int CW = $clog2(NUM_VOICES + 1);
  localparam int EW = ((IW > pva_pkg::SLOT_W) ? IW : pva_pkg::SLOT_W) + 1;

  typedef struct packed {
    logic                          playing;
    logic [pva_pkg::PRIO_W-1:0]    prio;
    logic [TIME_WIDTH-1:0]         stime;
    logic [pva_pkg::GEN_W-1:0]     gen;
  } entry_t;

  localparam int     ENTRY_W     = $bits(entry_t);
  localparam entry_t ENTRY_RESET = '{playing: 1'b0, prio: pva_pkg::PRIO_IDLE,
                                     stime: '0, gen: '0};

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_WRITE = 2'd2;
  localparam logic [1:0] S_REL   = 2'd3;

  logic [1:0]                 state;
  pva_pkg::req_t              req_q;
  logic [IW-1:0]              offset;
  logic [IW-1:0]              scan_addr;
  logic [CW-1:0]              issue_cnt;
  logic                       dv;
  logic [IW-1:0]              dv_addr;
  logic                       dv_last;
  logic                       found;
  logic [IW-1:0]              pick;
  logic [TIME_WIDTH-1:0]      pick_time;
  logic [pva_pkg::GEN_W-1:0]  pick_gen;
  logic [IW-1:0]              rel_addr;

  logic                       accept;
  logic                       rel_in_range;
  logic                       rd_en;
  logic [IW-1:0]              rd_addr;
  logic [ENTRY_W-1:0]         rd_data;
  entry_t                     ent;
  logic                       wr_en;
  logic [IW-1:0]              wr_addr;
  entry_t                     wr_data;
  logic [TIME_WIDTH-1:0]      now;
  logic [pva_pkg::GEN_W-1:0]  gen_next;
  logic [EW-1:0]              dv_ext;
  logic                       sounding;
  logic                       is_free;
  logic                       can_steal;

  assign busy         = (state != S_IDLE);
  assign accept       = start && !busy;
  assign rel_in_range = EW'(req.voice_slot) < EW'(NUM_VOICES);
  assign now          = TIME_WIDTH'(req_q.request_time);
  assign gen_next     = pick_gen + pva_pkg::GEN_W'(1);
  assign ent          = entry_t'(rd_data);

  assign dv_ext    = EW'(dv_addr);
  assign sounding  = (dv_ext < EW'(pva_pkg::MASK_W)) && req_q.mixer_active_mask[dv_ext[4:0]];
  assign is_free   = !ent.playing && !sounding;
  assign can_steal = (ent.prio >= req_q.request_priority) &&
                     (!found || (ent.stime < pick_time));

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = scan_addr;
    wr_en   = 1'b0;
    wr_addr = pick;
    wr_data = ENTRY_RESET;
    if (accept && (req.opcode == pva_pkg::OP_RELEASE) && rel_in_range) begin
      rd_en   = 1'b1;
      rd_addr = IW'(req.voice_slot);
    end
    if ((state == S_SCAN) && (issue_cnt < CW'(NUM_VOICES))) begin
      rd_en = 1'b1;
    end
    if (state == S_WRITE) begin
      wr_en           = 1'b1;
      wr_data.playing = 1'b1;
      wr_data.prio    = req_q.request_priority;
      wr_data.stime   = now;
      wr_data.gen     = gen_next;
    end
    if (state == S_REL) begin
      wr_en           = 1'b1;
      wr_addr         = rel_addr;
      wr_data         = ent;
      wr_data.playing = 1'b0;
      wr_data.prio    = pva_pkg::PRIO_IDLE;
    end
  end

  pva_voice_mem #(
    .DEPTH (NUM_VOICES),
    .WIDTH (ENTRY_W),
    .FILL  (ENTRY_RESET)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      offset <= '0;
      done   <= 1'b0;
      dv     <= 1'b0;
      found  <= 1'b0;
    end else begin
      done    <= 1'b0;
      dv      <= rd_en && (state == S_SCAN);
      dv_addr <= scan_addr;
      dv_last <= (issue_cnt == CW'(NUM_VOICES - 1));
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            req_q <= req;
            if (req.opcode == pva_pkg::OP_ALLOC) begin
              scan_addr <= offset;
              offset    <= (offset == IW'(NUM_VOICES - 1)) ? '0 : offset + IW'(1);
              issue_cnt <= '0;
              found     <= 1'b0;
              state     <= S_SCAN;
            end else if (rel_in_range) begin
              rel_addr <= IW'(req.voice_slot);
              state    <= S_REL;
            end else begin
              done   <= 1'b1;
              result <= '0;
            end
          end
        end
        S_SCAN: begin
          if (rd_en) begin
            issue_cnt <= issue_cnt + CW'(1);
            scan_addr <= (scan_addr == IW'(NUM_VOICES - 1)) ? '0 : scan_addr + IW'(1);
          end
          if (dv) begin
            if (is_free) begin
              found    <= 1'b1;
              pick     <= dv_addr;
              pick_gen <= ent.gen;
              state    <= S_WRITE;
            end else begin
              if (can_steal) begin
                found     <= 1'b1;
                pick      <= dv_addr;
                pick_time <= ent.stime;
                pick_gen  <= ent.gen;
              end
              if (dv_last) begin
                if (found || can_steal) begin
                  state <= S_WRITE;
                end else begin
                  done   <= 1'b1;
                  result <= '0;
                  state  <= S_IDLE;
                end
              end
            end
          end
        end
        S_WRITE: begin
          done                <= 1'b1;
          result.granted      <= 1'b1;
          result.granted_slot <= (pva_pkg::SLOT_W)'(pick);
          result.generation   <= gen_next;
          state               <= S_IDLE;
        end
        S_REL: begin
          done   <= 1'b1;
          result <= '0;
          state  <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `PVA_ASSERT_SAME(a_done_idle, done, !busy, "result strobe while busy")
  `PVA_ASSERT_NEXT(a_write_done, wr_en, done, "memory write without a result")
  `PVA_ASSERT_SAME(a_scan_no_write, state == S_SCAN, !wr_en, "write during scan")
  `PVA_ASSERT_NEXT(a_accept_moves, accept, busy || done, "item accepted but dropped")
  `PVA_ASSERT_SAME(a_grant_slot, done && result.granted, EW'(result.granted_slot) < EW'(NUM_VOICES), "granted voice out of range")

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int VOICES       = 32;
  localparam int ITEM_TARGET  = 1720;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = VOICES + 8;
  localparam int PHASE_ITEMS  = 120;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  pva_pkg::req_t req = '0;
  logic busy;
  logic done;
  pva_pkg::rsp_t result;

  priority_voice_allocator u_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .req    (req),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  // allocator state as the checker sees it
  logic             voice_playing [VOICES];
  logic [7:0]       voice_prio    [VOICES];
  logic [31:0]      voice_start   [VOICES];
  logic [31:0]      voice_gen     [VOICES];
  int unsigned      scan_offset;

  pva_pkg::req_t pending_requests [$];
  pva_pkg::rsp_t expected_grants  [$];
  int unsigned items_accepted = 0;
  int unsigned results_seen = 0;
  int unsigned error_count = 0;
  int unsigned release_count = 0;
  int unsigned free_count = 0;
  int unsigned steal_count = 0;
  int unsigned refused_count = 0;
  int unsigned stall_cycles = 0;
  logic [31:0] tick = 32'd0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    for (int v = 0; v < VOICES; v++) begin
      voice_playing[v] = 1'b0;
      voice_prio[v]    = pva_pkg::PRIO_IDLE;
      voice_start[v]   = 32'd0;
      voice_gen[v]     = 32'd0;
    end
    scan_offset = 0;
  end

  function automatic pva_pkg::rsp_t predict_allocation(input pva_pkg::req_t item);
    pva_pkg::rsp_t res;
    logic found;
    logic free_hit;
    int unsigned pick;
    int unsigned v;
    res = '0;
    found = 1'b0;
    free_hit = 1'b0;
    pick = 0;
    if (item.opcode == pva_pkg::OP_RELEASE) begin
      if (item.voice_slot < VOICES) begin
        voice_prio[item.voice_slot]    = pva_pkg::PRIO_IDLE;
        voice_playing[item.voice_slot] = 1'b0;
      end
      release_count++;
      return res;
    end
    for (int i = 0; i < VOICES; i++) begin
      v = (i + scan_offset) % VOICES;
      if (!voice_playing[v] && !item.mixer_active_mask[v]) begin
        found = 1'b1;
        free_hit = 1'b1;
        pick = v;
        break;
      end
      if (voice_prio[v] >= item.request_priority &&
          (!found || voice_start[v] < voice_start[pick])) begin
        found = 1'b1;
        pick = v;
      end
    end
    scan_offset = (scan_offset + 1) % VOICES;
    if (found) begin
      voice_prio[pick]    = item.request_priority;
      voice_start[pick]   = item.request_time;
      voice_gen[pick]     = voice_gen[pick] + 32'd1;
      voice_playing[pick] = 1'b1;
      res.granted         = 1'b1;
      res.granted_slot    = pick[4:0];
      res.generation      = voice_gen[pick];
      if (free_hit) free_count++;
      else steal_count++;
    end else begin
      refused_count++;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic queue_item(input logic op, input logic [7:0] prio, input logic [31:0] tm,
                            input logic [4:0] slot, input logic [31:0] mask);
    pva_pkg::req_t item;
    item.opcode            = op;
    item.request_priority  = prio;
    item.request_time      = tm;
    item.voice_slot        = slot;
    item.mixer_active_mask = mask;
    pending_requests.push_back(item);
  endtask

  task automatic queue_alloc(input logic [7:0] prio, input logic [31:0] tm,
                             input logic [31:0] mask);
    queue_item(pva_pkg::OP_ALLOC, prio, tm, 5'($urandom), mask);
  endtask

  task automatic queue_release(input logic [4:0] slot);
    queue_item(pva_pkg::OP_RELEASE, 8'($urandom), $urandom, slot, $urandom);
  endtask

  function automatic logic [31:0] random_mask();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 32'hFFFF_FFFF;
      4, 5, 6:    return $urandom | $urandom;
      7, 8:       return $urandom;
      default:    return 32'h0000_0000;
    endcase
  endfunction

  function automatic logic [31:0] next_time(input int mode);
    case (mode)
      0: begin
        tick = tick + $urandom_range(1, 1000);
        return tick;
      end
      1:       return $urandom;
      default: return 32'($urandom_range(0, 3));
    endcase
  endfunction

  // sender gap phases hold back start between items; the receiver cannot stall
  function automatic int gap_percent(input int unsigned count);
    case ((count / PHASE_ITEMS) % 4)
      1:       return 54;
      2:       return 13;
      default: return 0;
    endcase
  endfunction

  // driver
  always @(posedge clk) begin : driver
    logic nxt_start;
    if (rst) begin
      start <= 1'b0;
    end else begin
      nxt_start = start;
      if (start && !busy) begin
        expected_grants.push_back(predict_allocation(req));
        items_accepted++;
        nxt_start = 1'b0;
      end
      if (!(start && busy)) begin
        if (pending_requests.size() != 0 &&
            $urandom_range(0, 99) >= gap_percent(items_accepted)) begin
          req <= pending_requests.pop_front();
          nxt_start = 1'b1;
        end else begin
          nxt_start = 1'b0;
        end
      end
      start <= nxt_start;
    end
  end

  // monitor
  always @(posedge clk) begin : monitor
    pva_pkg::rsp_t exp;
    if (!rst && done) begin
      results_seen++;
      if (expected_grants.size() == 0) begin
        report_mismatch($sformatf("result with nothing outstanding: %p", result));
      end else begin
        exp = expected_grants.pop_front();
        if (result.granted !== exp.granted)
          report_mismatch($sformatf("granted %b, expected %b", result.granted, exp.granted));
        if (result.granted_slot !== exp.granted_slot)
          report_mismatch($sformatf("granted_slot %0d, expected %0d",
                                    result.granted_slot, exp.granted_slot));
        if (result.generation !== exp.generation)
          report_mismatch($sformatf("generation %0d, expected %0d",
                                    result.generation, exp.generation));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin : run_control
    int n;
    int kind;
    logic first;
    first = 1'b1;

    // directed items
    queue_item(pva_pkg::OP_ALLOC, 8'd0, 32'd0, 5'd0, 32'h0000_0000);
    queue_item(pva_pkg::OP_ALLOC, 8'd255, 32'hFFFF_FFFF, 5'd31, 32'hFFFF_FFFF);
    queue_item(pva_pkg::OP_ALLOC, 8'd128, 32'd5, 5'd0, 32'hFFFF_FFFF);
    queue_item(pva_pkg::OP_ALLOC, 8'd128, 32'd6, 5'd31, 32'h0000_0000);
    queue_item(pva_pkg::OP_RELEASE, 8'hFF, 32'hFFFF_FFFF, 5'd31, 32'hFFFF_FFFF);
    queue_item(pva_pkg::OP_RELEASE, 8'h00, 32'h0000_0000, 5'd0, 32'h0000_0000);
    queue_item(pva_pkg::OP_ALLOC, 8'd1, 32'd7, 5'd0, 32'hFFFF_FFFE);
    queue_item(pva_pkg::OP_ALLOC, 8'd200, 32'd8, 5'd0, 32'h8000_0000);
    queue_item(pva_pkg::OP_ALLOC, 8'd254, 32'd9, 5'd0, 32'h5555_5555);
    queue_item(pva_pkg::OP_ALLOC, 8'd255, 32'd9, 5'd0, 32'hAAAA_AAAA);
    queue_item(pva_pkg::OP_RELEASE, 8'hFF, 32'd0, 5'd16, 32'hFFFF_FFFF);
    queue_item(pva_pkg::OP_RELEASE, 8'h00, 32'd0, 5'd1, 32'h0000_0000);
    queue_item(pva_pkg::OP_ALLOC, 8'd0, 32'h8000_0000, 5'd0, 32'hFFFF_FFFF);
    queue_item(pva_pkg::OP_ALLOC, 8'd0, 32'h7FFF_FFFF, 5'd0, 32'hFFFF_FFFF);
    queue_item(pva_pkg::OP_ALLOC, 8'd255, 32'd1, 5'd0, 32'hFFFF_FFFF);
    queue_item(pva_pkg::OP_RELEASE, 8'h55, 32'h5555_5555, 5'd10, 32'h5555_5555);
    queue_item(pva_pkg::OP_RELEASE, 8'hAA, 32'hAAAA_AAAA, 5'd21, 32'hAAAA_AAAA);
    queue_item(pva_pkg::OP_ALLOC, 8'd100, 32'd2, 5'd0, 32'h0000_0001);

    // random episodes
    while (pending_requests.size() < ITEM_TARGET) begin
      kind = first ? 0 : $urandom_range(0, 3);
      first = 1'b0;
      case (kind)
        0: begin
          // fill every voice at low priority values, then ask with values above them
          n = $urandom_range(32, 40);
          for (int k = 0; k < n; k++)
            queue_alloc(8'($urandom_range(0, 99)), next_time(0),
                        $urandom_range(0, 1) ? 32'hFFFF_FFFF : random_mask());
          n = $urandom_range(2, 6);
          for (int k = 0; k < n; k++)
            queue_alloc(8'($urandom_range(100, 255)), next_time(1), 32'hFFFF_FFFF);
          n = $urandom_range(2, 5);
          for (int k = 0; k < n; k++) queue_release(5'($urandom));
          for (int k = 0; k < n; k++)
            queue_alloc(8'($urandom_range(100, 255)), next_time(0), 32'hFFFF_FFFF);
        end
        1: begin
          n = $urandom_range(10, 60);
          for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 4) == 0) queue_release(5'($urandom));
            else queue_alloc(8'($urandom), next_time($urandom_range(0, 2)), random_mask());
          end
        end
        2: begin
          // clustered start times give ties in the steal search
          n = $urandom_range(20, 50);
          for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 7) == 0) queue_release(5'($urandom));
            else queue_alloc(8'($urandom), next_time(2),
                             $urandom_range(0, 3) != 0 ? 32'hFFFF_FFFF : random_mask());
          end
        end
        default: begin
          n = $urandom_range(4, 20);
          for (int k = 0; k < n; k++) queue_release(5'($urandom));
          n = $urandom_range(4, 20);
          for (int k = 0; k < n; k++)
            queue_alloc(8'($urandom), next_time(0),
                        $urandom_range(0, 2) == 0 ? 32'h0000_0000 : random_mask());
        end
      endcase
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (pending_requests.size() != 0 || start || expected_grants.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d items and %0d results: %0d releases, %0d free grants,",
             items_accepted, results_seen, release_count, free_count);
    $display("  %0d steals and %0d refused allocations; %0d mismatches",
             steal_count, refused_count, error_count);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
